// ===== hw/rtl/e2q_pkg.sv =====
// Package for the Euler angle to quaternion unit.
// Holds widths, CORDIC constants and the arctangent table; no dependencies.
package e2q_pkg;

  localparam int AngleWidth = 16;
  localparam int OutWidth   = 16;
  localparam int CordicSteps = 30;
  localparam int CordicW    = 34;
  localparam int ZW         = 33;
  localparam logic signed [CordicW-1:0] CordicStart = 34'sd652032874;

  typedef logic signed [CordicW-1:0] cval_t;
  typedef logic signed [ZW-1:0] zval_t;

  // Arctangent of 2^-i in 32-bit turn units
  function automatic zval_t arc_of(input int i);
    zval_t r;
    r = '0;
    case (i)
      0:  r = 33'h020000000;  1:  r = 33'h012E4051D;  2:  r = 33'h009FB385B;
      3:  r = 33'h0051111D4;  4:  r = 33'h0028B0D43;  5:  r = 33'h00145D7E1;
      6:  r = 33'h000A2F61E;  7:  r = 33'h000517C55;  8:  r = 33'h00028BE53;
      9:  r = 33'h000145F2E;  10: r = 33'h0000A2F98;  11: r = 33'h0000517CC;
      12: r = 33'h000028BE6;  13: r = 33'h0000145F3;  14: r = 33'h00000A2F9;
      15: r = 33'h00000517C;  16: r = 33'h0000028BE;  17: r = 33'h00000145F;
      18: r = 33'h000000A2F;  19: r = 33'h000000517;  20: r = 33'h00000028B;
      21: r = 33'h000000145;  22: r = 33'h0000000A2;  23: r = 33'h000000051;
      24: r = 33'h000000028;  25: r = 33'h000000014;  26: r = 33'h00000000A;
      27: r = 33'h000000005;  28: r = 33'h000000002;  29: r = 33'h000000001;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/euler_to_quaternion_unit.sv =====
// Structure: input load, 30 CORDIC stages,
// 5 product and output stages.
// Throughput: one beat per cycle unless the output stalls; the CORDIC and multiplier pipeline takes a new beat
// each cycle and a stall on the output freezes every stage at once.
// Reset: rst_n synchronous active low clears all stage valid bits; data is not reset.
// Depends on e2q_pkg.
module euler_to_quaternion_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic signed [e2q_pkg::AngleWidth-1:0] in_roll_angle,
  input  logic signed [e2q_pkg::AngleWidth-1:0] in_pitch_angle,
  input  logic signed [e2q_pkg::AngleWidth-1:0] in_yaw_angle,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [e2q_pkg::OutWidth-1:0] out_quat_w,
  output logic signed [e2q_pkg::OutWidth-1:0] out_quat_x,
  output logic signed [e2q_pkg::OutWidth-1:0] out_quat_y,
  output logic signed [e2q_pkg::OutWidth-1:0] out_quat_z
);
  localparam int N  = e2q_pkg::CordicSteps;
  localparam int PS = 5;
  localparam int SH = 60 - (e2q_pkg::OutWidth - 1);

  // global advance: pipeline moves unless the last stage is blocked
  logic adv;
  assign adv = !out_valid || out_ready;
  assign in_ready = adv;

  // CORDIC stages, three lanes each
  e2q_pkg::cval_t cx_r [3][N+1];
  e2q_pkg::cval_t cy_r [3][N+1];
  e2q_pkg::zval_t cz_r [3][N+1];
  logic [N:0] cv_r;

  logic signed [e2q_pkg::AngleWidth-1:0] ang [3];
  assign ang[0] = in_roll_angle;
  assign ang[1] = in_pitch_angle;
  assign ang[2] = in_yaw_angle;

  always_ff @(posedge clk) begin
    if (!rst_n) cv_r <= '0;
    else if (adv) cv_r <= {cv_r[N-1:0], in_valid};
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    always_ff @(posedge clk) begin
      if (adv) begin
        cx_r[l][0] <= e2q_pkg::CordicStart;
        cy_r[l][0] <= '0;
        // half angle in turn units, sign extended
        cz_r[l][0] <= e2q_pkg::zval_t'(ang[l]) <<< (31 - e2q_pkg::AngleWidth);
      end
    end
    for (genvar i = 0; i < N; i++) begin : g_step
      e2q_pkg::cval_t dx, dy;
      assign dx = cy_r[l][i] >>> i;
      assign dy = cx_r[l][i] >>> i;
      always_ff @(posedge clk) begin
        if (adv) begin
          if (!cz_r[l][i][e2q_pkg::ZW-1]) begin
            cx_r[l][i+1] <= cx_r[l][i] - dx;
            cy_r[l][i+1] <= cy_r[l][i] + dy;
            cz_r[l][i+1] <= cz_r[l][i] - e2q_pkg::arc_of(i);
          end else begin
            cx_r[l][i+1] <= cx_r[l][i] + dx;
            cy_r[l][i+1] <= cy_r[l][i] - dy;
            cz_r[l][i+1] <= cz_r[l][i] + e2q_pkg::arc_of(i);
          end
        end
      end
    end
  end

  // Stage A: pair products (Q60), yaw delayed
  logic signed [67:0] pa_r [4];
  e2q_pkg::cval_t ya_c_r, ya_s_r, yb_c_r, yb_s_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      pa_r[0] <= 68'(cx_r[0][N] * cx_r[1][N]);
      pa_r[1] <= 68'(cy_r[0][N] * cy_r[1][N]);
      pa_r[2] <= 68'(cy_r[0][N] * cx_r[1][N]);
      pa_r[3] <= 68'(cx_r[0][N] * cy_r[1][N]);
      ya_c_r <= cx_r[2][N];
      ya_s_r <= cy_r[2][N];
    end
  end

  // Stage B: round pairs back to Q30
  e2q_pkg::cval_t pb_r [4];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++)
        pb_r[k] <= e2q_pkg::CordicW'((pa_r[k] + 68'sd536870912) >>> 30);
      yb_c_r <= ya_c_r;
      yb_s_r <= ya_s_r;
    end
  end

  // Stage C: triple products; order crcp, srsp, srcp, crsp times cy and sy
  logic signed [67:0] tc_r [4];
  logic signed [67:0] ts_r [4];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        tc_r[k] <= 68'(pb_r[k] * yb_c_r);
        ts_r[k] <= 68'(pb_r[k] * yb_s_r);
      end
    end
  end

  // Stage D: combine by the ZYX rule, add rounding bias
  logic signed [68:0] sd_r [4];
  localparam logic signed [68:0] Bias = 69'sd1 <<< (SH - 1);
  always_ff @(posedge clk) begin
    if (adv) begin
      sd_r[0] <= 69'(tc_r[0]) + 69'(ts_r[1]) + Bias;
      sd_r[1] <= 69'(tc_r[2]) - 69'(ts_r[3]) + Bias;
      sd_r[2] <= 69'(tc_r[3]) + 69'(ts_r[2]) + Bias;
      sd_r[3] <= 69'(ts_r[0]) - 69'(tc_r[1]) + Bias;
    end
  end

  // Stage E: shift and saturate into output register
  localparam logic signed [68:0] Hi = (69'sd1 <<< (e2q_pkg::OutWidth - 1)) - 69'sd1;
  localparam logic signed [68:0] Lo = -Hi - 69'sd1;
  logic signed [e2q_pkg::OutWidth-1:0] q_r [4];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        if ((sd_r[k] >>> SH) > Hi) q_r[k] <= Hi[e2q_pkg::OutWidth-1:0];
        else if ((sd_r[k] >>> SH) < Lo) q_r[k] <= Lo[e2q_pkg::OutWidth-1:0];
        else q_r[k] <= e2q_pkg::OutWidth'(sd_r[k] >>> SH);
      end
    end
  end

  logic [PS-1:0] pv_r;
  always_ff @(posedge clk) begin
    if (!rst_n) pv_r <= '0;
    else if (adv) pv_r <= {pv_r[PS-2:0], cv_r[N]};
  end

  assign out_valid  = pv_r[PS-1];
  assign out_quat_w = q_r[0];
  assign out_quat_x = q_r[1];
  assign out_quat_y = q_r[2];
  assign out_quat_z = q_r[3];
endmodule

// ===== hw/rtl/euler_to_quaternion_unit_chk.sv =====
// Port-level checker for euler_to_quaternion_unit, bound to the top level.
// Depends on e2q_pkg for widths.
module euler_to_quaternion_unit_chk (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic signed [e2q_pkg::OutWidth-1:0] out_quat_w
);
  // stalled result beat holds its valid and its w lane
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_quat_w))
    else $error("result beat changed while stalled");
  // ready follows output stall
  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");
  a_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");
  // no result right after reset
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");
endmodule

bind euler_to_quaternion_unit euler_to_quaternion_unit_chk u_chk (.*);
